@@ src/tec_pid_pwm_controller_core_assert.svh @@
// assertion macros shared by the tec pid pwm controller rtl
// no dependencies; bodies compile away when SYNTHESIS is defined
`ifndef TEC_PID_PWM_CONTROLLER_CORE_ASSERT_SVH
`define TEC_PID_PWM_CONTROLLER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define TECPID_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define TECPID_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TECPID_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define TECPID_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ src/tecpid_pkg.sv @@
// types and constants for the tec pid pwm controller
// used by tecpid_shaper and tec_pid_pwm_controller_core
`default_nettype none
package tecpid_pkg;

    localparam int unsigned DATA_W  = 16;
    localparam int unsigned ERR_W   = 17;
    localparam int unsigned DELTA_W = 18;
    localparam int unsigned ESUM_W  = 32;
    localparam int unsigned SUM_W   = 50;
    localparam int unsigned IDX_W   = 3;

    typedef enum logic [IDX_W-1:0] {
        REG_SETPOINT      = 3'd0,
        REG_PROP_GAIN     = 3'd1,
        REG_INTEG_GAIN    = 3'd2,
        REG_DERIV_GAIN    = 3'd3,
        REG_PWM_PERIOD    = 3'd4,
        REG_OUT_FLOOR     = 3'd5,
        REG_CURRENT_LIMIT = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] measured_temp;
        logic        [DATA_W-1:0] load_current;
    } in_t;

    typedef struct packed {
        logic [DATA_W-1:0] duty;
        logic [DATA_W-1:0] pid_level;
        logic              over_current;
        logic              below_target;
    } out_t;

    // status bits carried down the pipeline with each transaction
    typedef struct packed {
        logic over_current;
        logic below_target;
    } flags_t;

endpackage
`default_nettype wire

@@ src/tec_pid_pwm_controller_core.sv @@
// Positional PID temperature controller with PWM drive output. Each transaction
// on s_ carries a temperature sample and a load current; one result per sample
// comes out on m_ via registers a, b, c and out (error and saturating error
// sum, three Q8.8 gain products, their sum, then clamp, inversion and the
// overcurrent cut). A new sample can be accepted every cycle; the pipeline
// stalls stage by stage only when m_ready holds a result back, so up to four
// samples can be in flight. Error sum and previous error update at acceptance.
// Configuration writes take effect at once and belong between transactions.
`default_nettype none
`include "tec_pid_pwm_controller_core_assert.svh"
module tec_pid_pwm_controller_core (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire tecpid_pkg::in_t                     s_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output tecpid_pkg::out_t                         m_data,
    input  wire logic                                cfg_wr_en,
    input  wire logic [tecpid_pkg::IDX_W-1:0]        cfg_index,
    input  wire logic [tecpid_pkg::DATA_W-1:0]       cfg_wdata
);

    // configuration registers
    logic signed [tecpid_pkg::DATA_W-1:0] setpoint_reg;
    logic [tecpid_pkg::DATA_W-1:0] prop_gain_reg;
    logic [tecpid_pkg::DATA_W-1:0] integ_gain_reg;
    logic [tecpid_pkg::DATA_W-1:0] deriv_gain_reg;
    logic [tecpid_pkg::DATA_W-1:0] pwm_period_reg;
    logic [tecpid_pkg::DATA_W-1:0] out_floor_reg;
    logic [tecpid_pkg::DATA_W-1:0] current_limit_reg;

    // controller state
    logic signed [tecpid_pkg::ESUM_W-1:0] error_sum_reg;
    logic signed [tecpid_pkg::ESUM_W-1:0] error_sum_next;
    logic signed [tecpid_pkg::ERR_W-1:0]  last_error_reg;

    // stage a: error terms
    logic                                  a_valid_reg;
    logic signed [tecpid_pkg::ERR_W-1:0]   err_a_reg;
    logic signed [tecpid_pkg::ERR_W-1:0]   err_a_next;
    logic signed [tecpid_pkg::ESUM_W-1:0]  esum_a_reg;
    logic signed [tecpid_pkg::DELTA_W-1:0] delta_a_reg;
    logic signed [tecpid_pkg::DELTA_W-1:0] delta_a_next;
    tecpid_pkg::flags_t                    flags_a_reg;
    tecpid_pkg::flags_t                    flags_a_next;

    // stage b: products
    logic                                  b_valid_reg;
    logic signed [33:0]                    prod_p_reg;
    logic signed [48:0]                    prod_i_reg;
    logic signed [34:0]                    prod_d_reg;
    tecpid_pkg::flags_t                    flags_b_reg;

    // stage c: pid sum
    logic                                  c_valid_reg;
    logic signed [tecpid_pkg::SUM_W-1:0]   sum_c_reg;
    logic signed [tecpid_pkg::SUM_W-1:0]   sum_c_next;
    tecpid_pkg::flags_t                    flags_c_reg;

    // output register
    logic                                  out_valid_reg;
    tecpid_pkg::out_t                      out_data_reg;
    tecpid_pkg::out_t                      out_data_next;

    logic                                  a_en;
    logic                                  b_en;
    logic                                  c_en;
    logic                                  out_en;
    logic                                  s_fire;
    logic signed [tecpid_pkg::ESUM_W:0]    acc;

    // a stage may load when it is empty or its content moves on
    assign out_en  = !out_valid_reg || m_ready;
    assign c_en    = !c_valid_reg || out_en;
    assign b_en    = !b_valid_reg || c_en;
    assign a_en    = !a_valid_reg || b_en;
    assign s_ready = a_en;
    assign s_fire  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setpoint_reg      <= '0;
            prop_gain_reg     <= 16'd256;
            integ_gain_reg    <= '0;
            deriv_gain_reg    <= '0;
            pwm_period_reg    <= 16'd1000;
            out_floor_reg     <= '0;
            current_limit_reg <= 16'hFFFF;
        end else if (cfg_wr_en) begin
            unique case (tecpid_pkg::reg_idx_t'(cfg_index))
                tecpid_pkg::REG_SETPOINT:      setpoint_reg      <= cfg_wdata;
                tecpid_pkg::REG_PROP_GAIN:     prop_gain_reg     <= cfg_wdata;
                tecpid_pkg::REG_INTEG_GAIN:    integ_gain_reg    <= cfg_wdata;
                tecpid_pkg::REG_DERIV_GAIN:    deriv_gain_reg    <= cfg_wdata;
                tecpid_pkg::REG_PWM_PERIOD:    pwm_period_reg    <= cfg_wdata;
                tecpid_pkg::REG_OUT_FLOOR:     out_floor_reg     <= cfg_wdata;
                tecpid_pkg::REG_CURRENT_LIMIT: current_limit_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // error, saturating error sum and derivative difference
    assign err_a_next = {setpoint_reg[15], setpoint_reg}
                      - {s_data.measured_temp[15], s_data.measured_temp};
    assign acc = {error_sum_reg[31], error_sum_reg}
               + {{(tecpid_pkg::ESUM_W + 1 - tecpid_pkg::ERR_W){err_a_next[16]}}, err_a_next};

    always_comb begin
        if (acc[32] != acc[31]) begin
            error_sum_next = acc[32] ? {1'b1, {31{1'b0}}} : {1'b0, {31{1'b1}}};
        end else begin
            error_sum_next = acc[31:0];
        end
    end

    assign delta_a_next = {err_a_next[16], err_a_next} - {last_error_reg[16], last_error_reg};
    assign flags_a_next.over_current = s_data.load_current > current_limit_reg;
    assign flags_a_next.below_target = s_data.measured_temp < setpoint_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            error_sum_reg  <= '0;
            last_error_reg <= '0;
        end else if (s_fire) begin
            error_sum_reg  <= error_sum_next;
            last_error_reg <= err_a_next;
        end
    end

    assign sum_c_next = {{(tecpid_pkg::SUM_W - 34){prod_p_reg[33]}}, prod_p_reg}
                      + {{(tecpid_pkg::SUM_W - 49){prod_i_reg[48]}}, prod_i_reg}
                      + {{(tecpid_pkg::SUM_W - 35){prod_d_reg[34]}}, prod_d_reg};

    // pipeline control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (a_en)   a_valid_reg   <= s_valid;
            if (b_en)   b_valid_reg   <= a_valid_reg;
            if (c_en)   c_valid_reg   <= b_valid_reg;
            if (out_en) out_valid_reg <= c_valid_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            err_a_reg   <= err_a_next;
            esum_a_reg  <= error_sum_next;
            delta_a_reg <= delta_a_next;
            flags_a_reg <= flags_a_next;
        end
        if (b_en && a_valid_reg) begin
            prod_p_reg  <= $signed({1'b0, prop_gain_reg}) * err_a_reg;
            prod_i_reg  <= $signed({1'b0, integ_gain_reg}) * esum_a_reg;
            prod_d_reg  <= $signed({1'b0, deriv_gain_reg}) * delta_a_reg;
            flags_b_reg <= flags_a_reg;
        end
        if (c_en && b_valid_reg) begin
            sum_c_reg   <= sum_c_next;
            flags_c_reg <= flags_b_reg;
        end
        if (out_en && c_valid_reg) begin
            out_data_reg <= out_data_next;
        end
    end

    tecpid_shaper u_shaper (
        .sum        (sum_c_reg),
        .pwm_period (pwm_period_reg),
        .out_floor  (out_floor_reg),
        .flags      (flags_c_reg),
        .result     (out_data_next)
    );

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    `TECPID_ASSERT_NOW(a_level_in_period, aclk, aresetn, m_valid, m_data.pid_level <= pwm_period_reg, "pid level above period")
    `TECPID_ASSERT_NOW(a_below_zero_duty, aclk, aresetn, m_valid && m_data.below_target, m_data.duty == '0, "duty not zero below target")
    `TECPID_ASSERT_NOW(a_cut_duty_small, aclk, aresetn, m_valid && m_data.over_current, m_data.duty <= 16'd2, "overcurrent duty above two")
    `TECPID_ASSERT_NOW(a_stall_only_back, aclk, aresetn, !s_ready, m_valid && !m_ready, "input stalled without output backpressure")

endmodule
`default_nettype wire

@@ src/tecpid_shaper.sv @@
// output shaping: clamps the pid sum to a level, inverts it to a drive
// (zero below target) and applies the overcurrent cut; depends on tecpid_pkg
`default_nettype none
module tecpid_shaper (
    input  wire logic signed [tecpid_pkg::SUM_W-1:0]  sum,
    input  wire logic        [tecpid_pkg::DATA_W-1:0] pwm_period,
    input  wire logic        [tecpid_pkg::DATA_W-1:0] out_floor,
    input  wire tecpid_pkg::flags_t                   flags,
    output tecpid_pkg::out_t                          result
);

    logic signed [tecpid_pkg::SUM_W-1:0] period_q8;
    logic        [tecpid_pkg::DATA_W-1:0] floor_capped;
    logic        [tecpid_pkg::DATA_W-1:0] level;
    logic        [tecpid_pkg::DATA_W-1:0] drive;
    logic        [tecpid_pkg::DATA_W:0]   drive_x2;
    logic        [tecpid_pkg::DATA_W-1:0] duty;

    assign period_q8 = $signed({{(tecpid_pkg::SUM_W - tecpid_pkg::DATA_W - 8){1'b0}},
                                pwm_period, 8'h00});
    assign floor_capped = (out_floor > pwm_period) ? pwm_period : out_floor;

    always_comb begin
        if (sum > period_q8) begin
            level = pwm_period;
        end else if (sum[tecpid_pkg::SUM_W-1]) begin
            level = floor_capped;
        end else begin
            // sum is at most period*256 here, so bits 23:8 hold the whole level
            level = sum[tecpid_pkg::DATA_W+7:8];
        end
    end

    assign drive    = flags.below_target ? '0 : (pwm_period - level);
    assign drive_x2 = {drive, 1'b0};

    // drive never exceeds the period, so 2*drive/period is 0, 1 or 2
    always_comb begin
        if (!flags.over_current) begin
            duty = drive;
        end else if (pwm_period == '0) begin
            duty = '0;
        end else if (drive == pwm_period) begin
            duty = 16'd2;
        end else if (drive_x2 >= {1'b0, pwm_period}) begin
            duty = 16'd1;
        end else begin
            duty = '0;
        end
    end

    assign result.duty         = duty;
    assign result.pid_level    = level;
    assign result.over_current = flags.over_current;
    assign result.below_target = flags.below_target;

endmodule
`default_nettype wire
